@@ rtl/core/larl_pkg.sv @@
// Shared constants, types and codes for the login attempt rate limiter.
`default_nettype none
package larl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES = 1'b1;

  localparam logic [TIME_W-1:0]  WINDOW_MS_RST = 32'd60000;
  localparam logic [COUNT_W-1:0] MAX_TRIES_RST = 8'd5;

  localparam logic REQ_CHECK   = 1'b0;
  localparam logic REQ_SUCCESS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  wstart;
  } entry_t;

  // Outcome of one request: table write-back plus the result.
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_entry;
    logic               alloc;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/larl_entry_ram.sv @@
// Source entry table: one write port, one read port, registered read data.
`default_nettype none
module larl_entry_ram
  import larl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output entry_t                rdata
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/larl_decide.sv @@
// Window expiry, allow/block decision and entry write-back for one request.
`default_nettype none
module larl_decide
  import larl_pkg::*;
(
  input  wire logic               req_type,
  input  wire logic [ADDR_W-1:0]  req_addr,
  input  wire logic [TIME_W-1:0]  req_now,
  input  wire logic               found,
  input  wire logic [IDX_W-1:0]   hit_idx,
  input  wire entry_t             hit_entry,
  input  wire logic [FILL_W-1:0]  fill,
  input  wire logic [TIME_W-1:0]  window_ms,
  input  wire logic [COUNT_W-1:0] max_tries,
  output dec_t                    dec
);

  entry_t            base;
  logic [TIME_W-1:0] win_end;
  logic              expired;
  logic              full;

  always_comb begin
    full    = (fill == FILL_W'(TABLE_ENTRIES));
    base    = found ? hit_entry : '{addr: req_addr, count: '0, wstart: req_now};
    win_end = base.wstart + window_ms;
    expired = (base.wstart != '0) && (win_end < req_now);

    dec          = '0;
    dec.wr_idx   = found ? hit_idx : fill[IDX_W-1:0];
    dec.wr_entry = base;

    if (req_type == REQ_SUCCESS) begin
      if (!found) begin
        dec.status = ST_UNKNOWN;
      end else begin
        if (base.count != '0) begin
          dec.wr_entry.count = base.count - 1'b1;
        end
        dec.wr_en  = 1'b1;
        dec.status = ST_OK;
        dec.count  = dec.wr_entry.count;
      end
    end else if (!found && full) begin
      dec.status = ST_FULL;
    end else begin
      dec.alloc = !found;
      dec.wr_en = 1'b1;
      if (expired) begin
        dec.wr_entry.count  = '0;
        dec.wr_entry.wstart = req_now;
      end
      if (dec.wr_entry.count >= max_tries) begin
        dec.status = ST_BLOCKED;
      end else begin
        dec.wr_entry.count = dec.wr_entry.count + 1'b1;
        dec.status         = ST_OK;
      end
      dec.count = dec.wr_entry.count;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/larl_scan.sv @@
// Request sequencer: linear table scan, decision and write-back.
`default_nettype none
module larl_scan
  import larl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic [ADDR_W-1:0]  req_addr,
  input  wire logic [TIME_W-1:0]  req_now,
  input  wire logic [TIME_W-1:0]  window_ms,
  input  wire logic [COUNT_W-1:0] max_tries,
  output logic                    res_valid,
  output logic [1:0]              res_status,
  output logic [COUNT_W-1:0]      res_count
);

  state_t             state_r, state_nxt;
  logic               req_type_r;
  logic [ADDR_W-1:0]  req_addr_r;
  logic [TIME_W-1:0]  req_now_r;
  logic [FILL_W-1:0]  idx_r;
  logic               pend_r;
  logic [IDX_W-1:0]   pend_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  entry_t             hit_entry_r;
  logic [FILL_W-1:0]  fill_r;     // entries 0..fill-1 are in use
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  entry_t rd_entry;
  logic   accept;
  logic   hit;
  logic   more;
  logic   rd_en;
  dec_t   dec;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    hit   = pend_r && (rd_entry.addr == req_addr_r);
    more  = (idx_r != fill_r);
    rd_en = (state_r == S_SCAN) && !hit && more;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit || (!more && !pend_r)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  larl_entry_ram u_ram (
    .clk   (clk),
    .we    (state_r == S_DECIDE && dec.wr_en),
    .waddr (dec.wr_idx),
    .wdata (dec.wr_entry),
    .re    (rd_en),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  larl_decide u_decide (
    .req_type  (req_type_r),
    .req_addr  (req_addr_r),
    .req_now   (req_now_r),
    .found     (found_r),
    .hit_idx   (hit_idx_r),
    .hit_entry (hit_entry_r),
    .fill      (fill_r),
    .window_ms (window_ms),
    .max_tries (max_tries),
    .dec       (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= rd_en;
      out_valid_r <= (state_r == S_DECIDE);
      if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      if (rd_en) begin
        idx_r      <= idx_r + 1'b1;
        pend_idx_r <= idx_r[IDX_W-1:0];
      end
      if (state_r == S_SCAN && hit) begin
        found_r     <= 1'b1;
        hit_idx_r   <= pend_idx_r;
        hit_entry_r <= rd_entry;
      end
      if (state_r == S_DECIDE) begin
        out_status_r <= dec.status;
        out_count_r  <= dec.count;
        if (dec.alloc) fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= req_type;
      req_addr_r <= req_addr;
      req_now_r  <= req_now;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_status = out_status_r;
  assign res_count  = out_count_r;

endmodule
`default_nettype wire

@@ rtl/core/login_attempt_rate_limiter.sv @@
// Top level of the per-source fixed-window login attempt limiter.
//
// Pulse start with a request (check or success report) while busy is low;
// the request is taken on that edge and busy rises. The source table is
// searched one entry per clock through the single read port of the entry
// RAM, so a request keeps busy high longer as fill, the number of sources
// seen since reset, grows, and less long on an early hit. The result shows
// on out_status / out_attempt_count with out_valid high for exactly one
// cycle, the first cycle in which busy is low again. It is not held: the
// receiver must take it then. A new request may be started in that same
// cycle. Sources are only ever added, in order, so a fill count marks the
// live part of the table; reset clears it at once and no clearing pass is
// needed. Write window_ms / max_tries only while no request is in flight.
`default_nettype none
module login_attempt_rate_limiter
  import larl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_req_type,
  input  wire logic [ADDR_W-1:0]     in_source_addr,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  // result channel
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [COUNT_W-1:0]         out_attempt_count,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIME_W-1:0]  window_ms_r;
  logic [COUNT_W-1:0] max_tries_r;

  // Config registers; max_tries keeps the low byte of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= WINDOW_MS_RST;
      max_tries_r <= MAX_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_MS: window_ms_r <= cfg_wdata[TIME_W-1:0];
        REG_MAX_TRIES: max_tries_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, entry RAM and decision logic.
  larl_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (in_req_type),
    .req_addr   (in_source_addr),
    .req_now    (in_now_ms),
    .window_ms  (window_ms_r),
    .max_tries  (max_tries_r),
    .res_valid  (out_valid),
    .res_status (out_status),
    .res_count  (out_attempt_count)
  );

endmodule
`default_nettype wire
